// ----- rtl/core/cfss_pkg.sv -----
// Shared constants, types and byte helpers for the case folding substring search unit.
`default_nettype none

package cfss_pkg;

    localparam int MAX_NEEDLE = 32;
    localparam int IDX_W      = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 32;
    localparam int LEN_W      = 6;
    localparam int NIDX_W     = 5;
    localparam int CASE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BEFORE_OFFSET = 3'd4;

    // case modes
    localparam logic [CASE_W-1:0] CASE_EXACT       = 2'd0;
    localparam logic [CASE_W-1:0] CASE_INSENSITIVE = 2'd1;
    localparam logic [CASE_W-1:0] CASE_SMART       = 2'd2;

    localparam logic DIR_FORWARD  = 1'b0;
    localparam logic DIR_BACKWARD = 1'b1;

    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;

    // one haystack word handed from the cell row to the result stage
    typedef struct packed {
        logic             hit;
        logic             last;
        logic [POS_W-1:0] start;
    } cfss_item_t;

    function automatic logic is_upper(input logic [BYTE_W-1:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (is_upper(c))
        begin
            r = c + (CH_LOWER_A - CH_UPPER_A);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cfss_cell.sv -----
// One needle position: stored byte, comparator and partial-match bit.
`default_nettype none

module cfss_cell
    import cfss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [BYTE_W-1:0] wr_byte,
    input  wire logic              step,
    input  wire logic              clear,
    input  wire logic              sensitive,
    input  wire logic [BYTE_W-1:0] hay_byte,
    input  wire logic              prev_match,
    output logic                   match,
    output logic                   hit_bit,
    output logic                   upper
);

    logic [BYTE_W-1:0] needle_reg;
    logic              upper_reg;
    logic              match_reg;
    logic              match_next;
    logic [BYTE_W-1:0] cmp_byte;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            needle_reg <= wr_byte;
            upper_reg  <= is_upper(wr_byte);
        end
    end

    // hay_byte arrives already folded when the compare is insensitive
    assign cmp_byte = sensitive ? needle_reg : fold_lower(needle_reg);
    assign hit_bit  = prev_match && (hay_byte == cmp_byte);

    always_comb
    begin
        if (clear)
        begin
            match_next = 1'b0;
        end
        else if (step)
        begin
            match_next = hit_bit;
        end
        else
        begin
            match_next = match_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;
    assign upper = upper_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cfss_result.sv -----
// Match selection stage and output register.
`default_nettype none

module cfss_result
    import cfss_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire cfss_item_t       item,
    input  wire logic             direction,
    input  wire logic [POS_W-1:0] start_offset,
    input  wire logic [POS_W-1:0] before_offset,
    output logic                  stall,
    output logic                  out_valid,
    output logic                  out_found,
    output logic [POS_W-1:0]      out_offset,
    input  wire logic             out_ready
);

    logic             s2_valid_reg;
    logic             s2_valid_next;
    cfss_item_t       s2_item_reg;
    logic             seen_reg;
    logic             seen_next;
    logic [POS_W-1:0] best_reg;
    logic [POS_W-1:0] best_next;
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [POS_W-1:0] out_offset_reg;
    logic             blocked;
    logic             retire;
    logic             take;

    // hold only when a finished result would overwrite one still unread
    assign blocked = s2_valid_reg && s2_item_reg.last && out_valid_reg && !out_ready;
    assign retire  = s2_valid_reg && !blocked;
    assign stall   = blocked;

    assign s2_valid_next = blocked ? 1'b1 : item_valid;

    always_ff @(posedge clk)
    begin
        if (!blocked)
        begin
            s2_item_reg <= item;
        end
    end

    always_comb
    begin
        take = 1'b0;
        if (s2_item_reg.hit)
        begin
            if (direction == DIR_FORWARD)
            begin
                take = !seen_reg && (s2_item_reg.start >= start_offset);
            end
            else
            begin
                take = s2_item_reg.start < before_offset;
            end
        end
        seen_next = seen_reg || take;
        best_next = take ? s2_item_reg.start : best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            seen_reg      <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            if (retire)
            begin
                if (s2_item_reg.last)
                begin
                    seen_reg <= 1'b0;
                    best_reg <= '0;
                end
                else
                begin
                    seen_reg <= seen_next;
                    best_reg <= best_next;
                end
            end
            if (retire && s2_item_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire && s2_item_reg.last)
        begin
            out_found_reg  <= seen_next;
            out_offset_reg <= seen_next ? best_next : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_found  = out_found_reg;
    assign out_offset = out_offset_reg;

endmodule

`default_nettype wire

// ----- rtl/core/case_folding_substring_search_unit.sv -----
// Top level: config registers, row of needle cells, position counter, result stage.
//
// Usage: load the needle with words carrying tuser (mode) = 0, needle_index and
// byte_value in tdata, and set needle_length and the other registers through the
// write port while the block is idle. Then stream the haystack with tuser = 1,
// one byte per word; tlast marks its final byte. Each needle position is a cell
// that compares the incoming byte and hands its partial-match bit to the next
// cell, so one word is taken every cycle while the result stage does not stall.
// The result word (found, match_offset) of a tlast word passes the selection
// stage register and then the output register; other words give no result.
// Throughput: one word per cycle, set by the compare in the cell row, while the
// input is not held. A result waiting in the output register does not hold the
// input; input is held only when a second result reaches the selection stage
// before the first one is taken.
// Reset clears the registers to their defaults, the match bits, the position
// and the match state; the needle bytes are undefined until written.
`default_nettype none

module case_folding_substring_search_unit
    import cfss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,  // needle_index[4:0], byte_value[12:5]
    input  wire logic                  s_axis_tuser,  // mode
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [39:0]                m_axis_tdata,  // found[0], match_offset[32:1]
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic              direction_reg;
    logic [CASE_W-1:0] case_mode_reg;
    logic [LEN_W-1:0]  needle_length_reg;
    logic [POS_W-1:0]  start_offset_reg;
    logic [POS_W-1:0]  before_offset_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;

    logic              in_fire;
    logic              hay_fire;
    logic              stall;
    logic [NIDX_W-1:0] needle_index;
    logic [BYTE_W-1:0] byte_value;
    logic              len_ok;
    logic [LEN_W-1:0]  len_m1;
    logic              sensitive;
    logic [BYTE_W-1:0] hay_byte;

    logic [MAX_NEEDLE-1:0] match_vec;
    logic [MAX_NEEDLE-1:0] hit_vec;
    logic [MAX_NEEDLE-1:0] upper_vec;
    logic [MAX_NEEDLE-1:0] active_vec;

    cfss_item_t        item;
    logic              out_found;
    logic [POS_W-1:0]  out_offset;

    assign needle_index = s_axis_tdata[4:0];
    assign byte_value   = s_axis_tdata[12:5];

    assign s_axis_tready = !stall;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign hay_fire      = in_fire && s_axis_tuser;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg     <= DIR_FORWARD;
            case_mode_reg     <= CASE_SMART;
            needle_length_reg <= '0;
            start_offset_reg  <= '0;
            before_offset_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DIRECTION:     direction_reg     <= cfg_data[0];
                CFG_CASE_MODE:     case_mode_reg     <= cfg_data[CASE_W-1:0];
                CFG_NEEDLE_LENGTH: needle_length_reg <= cfg_data[LEN_W-1:0];
                CFG_START_OFFSET:  start_offset_reg  <= cfg_data[POS_W-1:0];
                CFG_BEFORE_OFFSET: before_offset_reg <= cfg_data[POS_W-1:0];
                default:           ;
            endcase
        end
    end

    assign len_ok = (needle_length_reg != '0) && (int'(needle_length_reg) <= MAX_NEEDLE);
    assign len_m1 = needle_length_reg - LEN_W'(1);

    always_comb
    begin
        case (case_mode_reg)
            CASE_EXACT:       sensitive = 1'b1;
            CASE_INSENSITIVE: sensitive = 1'b0;
            default:          sensitive = |(upper_vec & active_vec);
        endcase
    end

    assign hay_byte = sensitive ? byte_value : fold_lower(byte_value);

    for (genvar k = 0; k < MAX_NEEDLE; k++)
    begin : g_cell
        logic prev;

        if (k == 0)
        begin : g_first
            assign prev = 1'b1;
        end
        else
        begin : g_rest
            assign prev = match_vec[k-1];
        end

        assign active_vec[k] = len_ok && (int'(needle_length_reg) > k);

        cfss_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .wr_en      (in_fire && !s_axis_tuser && (int'(needle_index) == k)),
            .wr_byte    (byte_value),
            .step       (hay_fire && active_vec[k]),
            .clear      (hay_fire && s_axis_tlast),
            .sensitive  (sensitive),
            .hay_byte   (hay_byte),
            .prev_match (prev),
            .match      (match_vec[k]),
            .hit_bit    (hit_vec[k]),
            .upper      (upper_vec[k])
        );
    end

    // position saturates at all ones; cleared at the end of each haystack
    always_comb
    begin
        pos_next = pos_reg;
        if (hay_fire)
        begin
            if (s_axis_tlast)
            begin
                pos_next = '0;
            end
            else if (pos_reg != '1)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_comb
    begin
        item.hit   = len_ok && hit_vec[len_m1[IDX_W-1:0]];
        item.last  = s_axis_tlast;
        item.start = pos_reg - POS_W'(len_m1);
    end

    cfss_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (hay_fire),
        .item          (item),
        .direction     (direction_reg),
        .start_offset  (start_offset_reg),
        .before_offset (before_offset_reg),
        .stall         (stall),
        .out_valid     (m_axis_tvalid),
        .out_found     (out_found),
        .out_offset    (out_offset),
        .out_ready     (m_axis_tready)
    );

    assign m_axis_tdata = {7'b0, out_offset, out_found};

endmodule

`default_nettype wire

// ----- tb/sv/case_folding_substring_search_unit_test.sv -----
// Self-checking testbench for the case folding substring search unit.
`default_nettype none

module case_folding_substring_search_unit_test
    import cfss_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_WORDS  = 660;

    localparam logic [CASE_W-1:0] CASE_UNUSED = 2'd3;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_BIT    = 8'h20;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] offset;
    } search_result_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata   = '0;  // needle_index[4:0], byte_value[12:5]
    logic                  s_axis_tuser   = 1'b0;  // mode
    logic                  s_axis_tlast   = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [39:0]           m_axis_tdata;  // found[0], match_offset[32:1]
    logic                  cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    // register and search state as the block should hold it
    logic                  cur_direction;
    logic [CASE_W-1:0]     cur_case_mode;
    logic [LEN_W-1:0]      cur_needle_len;
    logic [POS_W-1:0]      cur_start;
    logic [POS_W-1:0]      cur_before;
    logic [BYTE_W-1:0]     needle_copy [MAX_NEEDLE];
    logic [MAX_NEEDLE-1:0] partial_bits;
    logic [POS_W-1:0]      scan_pos;
    logic                  match_seen;
    logic [POS_W-1:0]      best_start;

    search_result_t pending_matches[$];
    search_result_t head_result;
    int             error_count = 0;
    int             words_sent  = 0;
    int             burst_left  = 0;
    rx_style_t      rx_style    = RX_ALWAYS;
    int             rx_left     = 0;

    case_folding_substring_search_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // receiver: switches at random between stall styles for the ready signal
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_style <= rx_style_t'($urandom_range(0, 3));
            rx_left  <= $urandom_range(16, 120);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_ALWAYS: m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default:   m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_matches.size() == 0)
            begin
                $display("%0t: unexpected result word: expected none, actual found=%0b offset=%0d",
                         $time, m_axis_tdata[0], m_axis_tdata[POS_W:1]);
                error_count++;
            end
            else
            begin
                head_result = pending_matches.pop_front();
                if (m_axis_tdata[0] !== head_result.found)
                begin
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $time, head_result.found, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[POS_W:1] !== head_result.offset)
                begin
                    $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                             $time, head_result.offset, m_axis_tdata[POS_W:1]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] to_lower_ascii(input logic [BYTE_W-1:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            return c + (CH_LOWER_A - CH_UPPER_A);
        end
        return c;
    endfunction

    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    // smart mode: exact compare once the active needle holds a capital letter
    function automatic logic needs_exact_case(input int len);
        if (cur_case_mode == CASE_EXACT)
        begin
            return 1'b1;
        end
        if (cur_case_mode == CASE_INSENSITIVE)
        begin
            return 1'b0;
        end
        for (int k = 0; k < len; k++)
        begin
            if (needle_copy[k] >= CH_UPPER_A && needle_copy[k] <= CH_UPPER_Z)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void clear_search_state();
        partial_bits = '0;
        scan_pos     = '0;
        match_seen   = 1'b0;
        best_start   = '0;
    endfunction

    function automatic void track_word(input logic mode, input logic [NIDX_W-1:0] idx,
                                       input logic [BYTE_W-1:0] value, input logic last);
        logic [MAX_NEEDLE-1:0] bits_next;
        logic                  exact;
        logic [BYTE_W-1:0]     hay_c;
        logic [BYTE_W-1:0]     ndl_c;
        logic [POS_W-1:0]      first_pos;
        int                    len;
        search_result_t        res;
        if (mode == 1'b0)
        begin
            needle_copy[idx] = value;
            return;
        end
        len = int'(cur_needle_len);
        if (len != 0 && len <= MAX_NEEDLE)
        begin
            exact     = needs_exact_case(len);
            hay_c     = exact ? value : to_lower_ascii(value);
            bits_next = partial_bits;
            for (int k = 0; k < len; k++)
            begin
                ndl_c        = exact ? needle_copy[k] : to_lower_ascii(needle_copy[k]);
                bits_next[k] = ((k == 0) ? 1'b1 : partial_bits[k - 1]) && (hay_c == ndl_c);
            end
            partial_bits = bits_next;
            if (partial_bits[len - 1])
            begin
                first_pos = scan_pos - POS_W'(len - 1);
                if (cur_direction == DIR_FORWARD)
                begin
                    if (!match_seen && first_pos >= cur_start)
                    begin
                        match_seen = 1'b1;
                        best_start = first_pos;
                    end
                end
                else if (first_pos < cur_before)
                begin
                    match_seen = 1'b1;
                    best_start = first_pos;
                end
            end
        end
        if (scan_pos != '1)
        begin
            scan_pos++;
        end
        if (last)
        begin
            res.found  = match_seen;
            res.offset = match_seen ? best_start : '0;
            pending_matches.push_back(res);
            clear_search_state();
        end
    endfunction

    task automatic send_word(input logic mode, input logic [NIDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] value, input logic last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {3'b000, value, idx};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        track_word(mode, idx, value, last);
        words_sent++;
    endtask

    task automatic send_needle(input logic [NIDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        send_word(1'b0, idx, value, 1'b0);
    endtask

    task automatic send_hay(input logic [BYTE_W-1:0] value, input logic last);
        send_word(1'b1, '0, value, last);
    endtask

    // hold the input until every result is out and the pipeline is empty
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_matches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (index)
            CFG_DIRECTION:     cur_direction  = value[0];
            CFG_CASE_MODE:     cur_case_mode  = value[CASE_W-1:0];
            CFG_NEEDLE_LENGTH: cur_needle_len = value[LEN_W-1:0];
            CFG_START_OFFSET:  cur_start      = value;
            CFG_BEFORE_OFFSET: cur_before     = value;
            default: ;
        endcase
    endtask

    // mostly a few letters of both cases, plus the bytes around the letter ranges
    function automatic logic [BYTE_W-1:0] text_byte();
        case ($urandom_range(0, 9))
            0: return BYTE_W'($urandom_range(0, 255));
            1:
            begin
                case ($urandom_range(0, 5))
                    0: return CH_UPPER_A - 8'd1;
                    1: return CH_UPPER_Z + 8'd1;
                    2: return CH_LOWER_A - 8'd1;
                    3: return CH_LOWER_Z + 8'd1;
                    4: return 8'h00;
                    default: return 8'hFF;
                endcase
            end
            2, 3, 4: return CH_LOWER_A + BYTE_W'($urandom_range(0, 1));
            5, 6, 7: return CH_UPPER_A + BYTE_W'($urandom_range(0, 1));
            default: return $urandom_range(0, 1) ? CH_LOWER_Z : CH_UPPER_Z;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] index);
        case (index)
            CFG_DIRECTION: return CFG_DATA_W'($urandom_range(0, 1));
            CFG_CASE_MODE: return CFG_DATA_W'($urandom_range(0, 3));
            CFG_NEEDLE_LENGTH:
            begin
                case ($urandom_range(0, 19))
                    0: return '0;
                    1: return CFG_DATA_W'(MAX_NEEDLE);
                    2: return CFG_DATA_W'($urandom_range(MAX_NEEDLE + 1, 63));
                    3, 4, 5, 6: return CFG_DATA_W'($urandom_range(7, MAX_NEEDLE - 1));
                    default: return CFG_DATA_W'($urandom_range(1, 6));
                endcase
            end
            CFG_START_OFFSET:
            begin
                case ($urandom_range(0, 7))
                    0: return '1;
                    1, 2, 3: return '0;
                    default: return CFG_DATA_W'($urandom_range(0, 24));
                endcase
            end
            CFG_BEFORE_OFFSET:
            begin
                case ($urandom_range(0, 7))
                    0: return '0;
                    1: return '1;
                    default: return CFG_DATA_W'($urandom_range(1, 40));
                endcase
            end
            default: return '0;
        endcase
    endfunction

    function automatic int active_len();
        return (cur_needle_len <= MAX_NEEDLE) ? int'(cur_needle_len) : 0;
    endfunction

    // haystack made of random text with needle copies spliced in, case flipped at random
    task automatic random_haystack(input int n);
        int                   copy_at;
        int                   len;
        logic [BYTE_W-1:0]    b;
        logic [CFG_IDX_W-1:0] reg_sel;
        copy_at = -1;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2 && n > 2 && $urandom_range(0, 7) == 0)
            begin
                if ($urandom_range(0, 1))
                begin
                    send_needle(NIDX_W'($urandom), text_byte());
                end
                else
                begin
                    reg_sel = CFG_IDX_W'($urandom_range(0, 4));
                    set_reg(reg_sel, pick_reg_value(reg_sel));
                end
            end
            len = active_len();
            if (copy_at < 0 && len != 0 && $urandom_range(0, 3) == 0)
            begin
                copy_at = 0;
            end
            if (copy_at >= 0 && copy_at < len)
            begin
                b = needle_copy[copy_at];
                if (is_letter(b) && $urandom_range(0, 3) == 0)
                begin
                    b = b ^ CASE_BIT;
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    b = text_byte();
                end
                copy_at++;
                if (copy_at >= len)
                begin
                    copy_at = -1;
                end
            end
            else
            begin
                copy_at = -1;
                b = text_byte();
            end
            send_word(1'b1, NIDX_W'($urandom), b, i == n - 1);
        end
    endtask

    // zero needle length never matches; last on a needle word is ignored
    task automatic test_empty_needle();
        send_word(1'b0, 5'd0, CH_LOWER_A, 1'b1);
        send_needle(5'd1, CH_UPPER_A + 8'd1);
        send_needle(5'd2, 8'h00);
        send_needle(5'd31, 8'hFF);
        send_hay(CH_LOWER_A, 1'b1);
    endtask

    // needle "aB": smart mode goes exact, then each case mode in turn
    task automatic test_case_modes();
        set_reg(CFG_NEEDLE_LENGTH, 2);
        send_hay(CH_UPPER_A, 1'b0);
        send_hay(CH_LOWER_A, 1'b0);
        send_hay(CH_UPPER_A + 8'd1, 1'b1);
        set_reg(CFG_CASE_MODE, CFG_DATA_W'(CASE_INSENSITIVE));
        set_reg(CFG_START_OFFSET, 1);
        send_hay(CH_UPPER_A, 1'b0);
        send_hay(CH_LOWER_A + 8'd1, 1'b0);
        send_hay(CH_LOWER_A, 1'b0);
        send_hay(CH_LOWER_A + 8'd1, 1'b1);
        set_reg(CFG_START_OFFSET, 0);
        set_reg(CFG_CASE_MODE, CFG_DATA_W'(CASE_UNUSED));
        send_hay(CH_UPPER_A, 1'b0);
        send_hay(CH_UPPER_A + 8'd1, 1'b1);
        set_reg(CFG_CASE_MODE, CFG_DATA_W'(CASE_EXACT));
        send_hay(CH_LOWER_A, 1'b0);
        send_hay(CH_UPPER_A + 8'd1, 1'b1);
    endtask

    task automatic test_byte_extremes();
        set_reg(CFG_CASE_MODE, CFG_DATA_W'(CASE_INSENSITIVE));
        set_reg(CFG_NEEDLE_LENGTH, 3);
        send_hay(8'hFF, 1'b0);
        send_hay(CH_UPPER_A, 1'b0);
        send_hay(CH_LOWER_A + 8'd1, 1'b0);
        send_hay(8'h00, 1'b1);
    endtask

    // before offset zero, a strict bound, and the maximum
    task automatic test_backward();
        set_reg(CFG_NEEDLE_LENGTH, 1);
        set_reg(CFG_DIRECTION, CFG_DATA_W'(DIR_BACKWARD));
        for (int pass = 0; pass < 3; pass++)
        begin
            set_reg(CFG_BEFORE_OFFSET, (pass == 0) ? 32'd0 : (pass == 1) ? 32'd2 : '1);
            send_hay(CH_LOWER_A, 1'b0);
            send_hay(CH_LOWER_Z - 8'd2, 1'b0);
            send_hay(CH_UPPER_A, 1'b1);
        end
    endtask

    task automatic test_offset_limits();
        set_reg(CFG_DIRECTION, CFG_DATA_W'(DIR_FORWARD));
        set_reg(CFG_START_OFFSET, '1);
        send_hay(CH_LOWER_A, 1'b1);
        set_reg(CFG_START_OFFSET, 0);
        set_reg(CFG_NEEDLE_LENGTH, 63);
        send_hay(CH_LOWER_A, 1'b1);
    endtask

    task automatic test_random_searches();
        int stop_at;
        int len;
        for (int k = 0; k < MAX_NEEDLE; k++)
        begin
            send_needle(NIDX_W'(k), text_byte());
        end
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at)
        begin
            for (int r = 0; r <= int'(CFG_BEFORE_OFFSET); r++)
            begin
                if ($urandom_range(0, 1))
                begin
                    set_reg(CFG_IDX_W'(r), pick_reg_value(CFG_IDX_W'(r)));
                end
            end
            len = active_len();
            for (int k = 0; k < len && k < 8; k++)
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    send_needle(NIDX_W'(k), text_byte());
                end
            end
            repeat ($urandom_range(1, 4))
            begin
                random_haystack($urandom_range(1, 12) + active_len());
            end
        end
    endtask

    initial
    begin
        int waited;
        cur_direction  = DIR_FORWARD;
        cur_case_mode  = CASE_SMART;
        cur_needle_len = '0;
        cur_start      = '0;
        cur_before     = '0;
        for (int k = 0; k < MAX_NEEDLE; k++)
        begin
            needle_copy[k] = '0;
        end
        clear_search_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_needle();
        test_case_modes();
        test_byte_extremes();
        test_backward();
        test_offset_limits();
        test_random_searches();

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_matches.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_matches.size() != 0)
        begin
            $display("%0t: %0d result words never arrived: expected found=%0b offset=%0d",
                     $time, pending_matches.size(), pending_matches[0].found,
                     pending_matches[0].offset);
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/cfss_pkg.sv
rtl/core/cfss_cell.sv
rtl/core/cfss_result.sv
rtl/core/case_folding_substring_search_unit.sv
tb/sv/case_folding_substring_search_unit_test.sv
